// File: rtl/pipct_pkg.sv
// shared types and constants for the point-in-polygon crossing test
`default_nettype none
package pipct_pkg;

	localparam int COORD_W      = 32;
	localparam int REL_W        = COORD_W + 1;
	localparam int PROD_W       = 2 * REL_W;
	localparam int NUDGE_W      = 16;
	localparam int CNT_W        = 11;
	localparam int MAX_VERTICES = 1024;
	localparam int CNT_SAT      = (MAX_VERTICES < 2047) ? MAX_VERTICES : 2047;
	localparam int QUEUE_DEPTH  = 4;

	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;
	localparam logic [PADDR_W-3:0] REG_ZERO_NUDGE = 1'b0;
	localparam logic [NUDGE_W-1:0] ZERO_NUDGE_RST = 16'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] vert_x;
		logic signed [COORD_W-1:0] vert_y;
		logic signed [COORD_W-1:0] vert_z;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [COORD_W-1:0] normal_x;
		logic signed [COORD_W-1:0] normal_y;
		logic signed [COORD_W-1:0] normal_z;
		logic                      first_vertex;
		logic                      last_vertex;
	} pipct_item_t;

	typedef struct packed {
		logic             inside_res;
		logic [CNT_W-1:0] crossing_count;
	} pipct_result_t;

	// one edge between front and back
	typedef struct packed {
		logic signed [REL_W-1:0] au;
		logic signed [REL_W-1:0] av;
		logic signed [REL_W-1:0] bu;
		logic signed [REL_W-1:0] bv;
		logic                    clear;
		logic                    straddle;
		logic                    last;
		logic                    on_vtx;
	} pipct_seg_t;

endpackage
`default_nettype wire

// File: rtl/pipct_fifo.sv
// small flop-based queue, depth a power of two
`default_nettype none
module pipct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wp_q;
	logic [AW:0]      rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
	assign rdata = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q[AW-1:0]] <= wdata;
		end
	end

endmodule
`default_nettype wire

// File: rtl/pipct_front.sv
// front end: axis select, relative coordinates, nudge and edge forming
`default_nettype none
module pipct_front
	import pipct_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire pipct_item_t        item,
	input  wire logic [NUDGE_W-1:0] zero_nudge,
	output logic                    seg_push,
	output pipct_seg_t              seg_word,
	input  wire logic               seg_full
);

	typedef enum logic [1:0] {
		DROP_X = 2'd0,
		DROP_Y = 2'd1,
		DROP_Z = 2'd2
	} axis_t;

	axis_t                     drop_axis_q;
	logic signed [COORD_W-1:0] point_u_q;
	logic signed [COORD_W-1:0] point_v_q;
	logic signed [REL_W-1:0]   prev_u_q;
	logic signed [REL_W-1:0]   prev_v_q;
	logic                      on_vertex_q;

	logic                      valid_s1;
	logic signed [COORD_W-1:0] u_s1;
	logic signed [COORD_W-1:0] v_s1;
	logic                      first_s1;
	logic                      last_s1;

	logic [COORD_W-1:0]        ax;
	logic [COORD_W-1:0]        ay;
	logic [COORD_W-1:0]        az;
	axis_t                     axis_new;
	axis_t                     axis_eff;
	logic signed [COORD_W-1:0] vu;
	logic signed [COORD_W-1:0] vv;
	logic signed [COORD_W-1:0] pu;
	logic signed [COORD_W-1:0] pv;
	logic                      accept;
	logic                      advance;

	logic signed [REL_W-1:0]   du;
	logic signed [REL_W-1:0]   dv;
	logic signed [REL_W-1:0]   nudge;
	logic signed [REL_W-1:0]   bu;
	logic signed [REL_W-1:0]   bv;
	logic                      at_point;
	logic                      straddle;
	logic                      on_next;
	logic                      upd_prev;

	assign ax = item.normal_x[COORD_W-1] ? COORD_W'(-item.normal_x) : item.normal_x;
	assign ay = item.normal_y[COORD_W-1] ? COORD_W'(-item.normal_y) : item.normal_y;
	assign az = item.normal_z[COORD_W-1] ? COORD_W'(-item.normal_z) : item.normal_z;

	always_comb begin
		if (ax > ay && ax > az) begin
			axis_new = DROP_X;
		end else if (ay > ax && ay > az) begin
			axis_new = DROP_Y;
		end else begin
			axis_new = DROP_Z;
		end
		axis_eff = item.first_vertex ? axis_new : drop_axis_q;
		case (axis_eff)
			DROP_X: begin
				vu = item.vert_y;
				vv = item.vert_z;
				pu = item.point_y;
				pv = item.point_z;
			end
			DROP_Y: begin
				vu = item.vert_z;
				vv = item.vert_x;
				pu = item.point_z;
				pv = item.point_x;
			end
			default: begin
				vu = item.vert_x;
				vv = item.vert_y;
				pu = item.point_x;
				pv = item.point_y;
			end
		endcase
	end

	assign advance = valid_s1 && !seg_full;
	assign full    = valid_s1 && seg_full;
	assign accept  = push && !full;

	// relative coordinates against the latched point
	assign du    = REL_W'({u_s1[COORD_W-1], u_s1} - {point_u_q[COORD_W-1], point_u_q});
	assign dv    = REL_W'({v_s1[COORD_W-1], v_s1} - {point_v_q[COORD_W-1], point_v_q});
	assign nudge = REL_W'({{(REL_W-NUDGE_W){1'b0}}, zero_nudge});

	always_comb begin
		at_point = (du == '0) && (dv == '0);
		if (first_s1 && at_point) begin
			bu = du;
			bv = dv;
		end else begin
			bu = (du == '0) ? nudge : du;
			bv = (dv == '0) ? nudge : dv;
		end
		on_next  = first_s1 ? at_point : on_vertex_q;
		upd_prev = first_s1 || !on_vertex_q;
		straddle = !first_s1 && !on_vertex_q &&
			((prev_v_q < 0 && bv > 0) || (prev_v_q > 0 && bv < 0));
	end

	always_comb begin
		seg_push          = advance;
		seg_word.au       = prev_u_q;
		seg_word.av       = prev_v_q;
		seg_word.bu       = bu;
		seg_word.bv       = bv;
		seg_word.clear    = first_s1;
		seg_word.straddle = straddle;
		seg_word.last     = last_s1;
		seg_word.on_vtx   = on_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_axis_q <= DROP_X;
			point_u_q   <= '0;
			point_v_q   <= '0;
			prev_u_q    <= '0;
			prev_v_q    <= '0;
			on_vertex_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept && item.first_vertex) begin
				drop_axis_q <= axis_new;
				point_u_q   <= pu;
				point_v_q   <= pv;
			end
			if (advance) begin
				on_vertex_q <= on_next;
				if (upd_prev) begin
					prev_u_q <= bu;
					prev_v_q <= bv;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_s1     <= vu;
			v_s1     <= vv;
			first_s1 <= item.first_vertex;
			last_s1  <= item.last_vertex;
		end
	end

endmodule
`default_nettype wire

// File: rtl/pipct_back.sv
// back end: cross products, crossing decision and count
`default_nettype none
module pipct_back
	import pipct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire pipct_seg_t seg_word,
	input  wire logic       seg_empty,
	output logic            seg_pop,
	output logic            res_push,
	output pipct_result_t   res_word,
	input  wire logic       res_full
);

	logic                     valid_s1;
	logic signed [PROD_W-1:0] p1_s1;
	logic signed [PROD_W-1:0] p2_s1;
	logic                     pos_s1;
	logic                     dir_s1;
	logic                     straddle_s1;
	logic                     clear_s1;
	logic                     last_s1;
	logic                     on_s1;
	logic [CNT_W-1:0]         cnt_q;

	logic                     advance;
	logic                     hit;
	logic [CNT_W-1:0]         cnt_base;
	logic [CNT_W-1:0]         cnt_new;

	assign advance = !(valid_s1 && last_s1 && res_full);
	assign seg_pop = advance && !seg_empty;

	always_comb begin
		hit = straddle_s1 && (pos_s1 || (dir_s1 ? (p1_s1 > p2_s1) : (p1_s1 < p2_s1)));
		cnt_base = clear_s1 ? '0 : cnt_q;
		cnt_new  = (hit && cnt_base < CNT_W'(CNT_SAT)) ? cnt_base + 1'b1 : cnt_base;
		res_push = advance && valid_s1 && last_s1;
		res_word.inside_res     = on_s1 | cnt_new[0];
		res_word.crossing_count = on_s1 ? '0 : cnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (advance) begin
			valid_s1 <= !seg_empty;
			if (valid_s1) begin
				cnt_q <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seg_pop) begin
			p1_s1       <= PROD_W'(seg_word.au * seg_word.bv);
			p2_s1       <= PROD_W'(seg_word.bu * seg_word.av);
			pos_s1      <= (seg_word.au > 0) && (seg_word.bu > 0);
			dir_s1      <= seg_word.bv > seg_word.av;
			straddle_s1 <= seg_word.straddle;
			clear_s1    <= seg_word.clear;
			last_s1     <= seg_word.last;
			on_s1       <= seg_word.on_vtx;
		end
	end

endmodule
`default_nettype wire

// File: rtl/point_in_polygon_crossing_test_unit.sv
// top level of the point-in-polygon crossing test
// one vertex word per cycle sustained while the result queue has room; every stage
// (axis select, offset and nudge, the two 33x33 cross products, the final compare and
// count) takes one word per cycle; results pass both stage registers and both queues
// reset clears all control state, the count and the latched point; zero_nudge resets to 7
// no clearing pass after reset: the block takes words in the first cycle
`default_nettype none
module point_in_polygon_crossing_test_unit
	import pipct_pkg::*;
#(
	parameter int QUEUE_DEPTH = pipct_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire pipct_item_t        item,
	output logic                    empty,
	input  wire logic               pop,
	output pipct_result_t           result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic [NUDGE_W-1:0] zero_nudge_q;
	logic               seg_push;
	pipct_seg_t         seg_in;
	logic               seg_full;
	pipct_seg_t         seg_out;
	logic               seg_empty;
	logic               seg_pop;
	logic               res_push;
	pipct_result_t      res_word;
	logic               res_full;
	logic               reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_ZERO_NUDGE);
	assign prdata  = reg_hit ? PDATA_W'(zero_nudge_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_nudge_q <= ZERO_NUDGE_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			zero_nudge_q <= pwdata[NUDGE_W-1:0];
		end
	end

	pipct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.zero_nudge (zero_nudge_q),
		.seg_push   (seg_push),
		.seg_word   (seg_in),
		.seg_full   (seg_full)
	);

	pipct_fifo #(
		.WIDTH ($bits(pipct_seg_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_seg_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (seg_push),
		.wdata  (seg_in),
		.full   (seg_full),
		.pop    (seg_pop),
		.rdata  (seg_out),
		.empty  (seg_empty)
	);

	pipct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_word  (seg_out),
		.seg_empty (seg_empty),
		.seg_pop   (seg_pop),
		.res_push  (res_push),
		.res_word  (res_word),
		.res_full  (res_full)
	);

	pipct_fifo #(
		.WIDTH ($bits(pipct_result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_word),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire
